// ----- hw/rtl/tee_pkg.sv -----
// shared types and constants of the token expression evaluator
package tee_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned MaxNest = 8;

  typedef enum logic [1:0] {
    TOK_NUM   = 2'd0,
    TOK_OP    = 2'd1,
    TOK_OPEN  = 2'd2,
    TOK_CLOSE = 2'd3
  } tok_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_AND = 3'd5,
    OP_OR  = 3'd6,
    OP_UNK = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_OPER  = 2'd1,
    PH_NEXT  = 2'd2
  } phase_e;

  // controller to datapath commands
  typedef struct packed {
    logic       load_tok;   // capture the incoming word
    logic       exec_tok;   // apply token in a single step (no arithmetic wait)
    logic       start_alu;  // start a combine
    logic       alu_pop;    // combine operands come from stack top
    logic       finish;     // present result, restart expression
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic needs_alu;   // loaded token needs an arithmetic combine
    logic needs_pop;   // that combine closes a group
    logic alu_done;
    logic nest_empty;
    logic is_last;
  } sts_t;

endpackage

// ----- hw/rtl/tee_divider.sv -----
// iterative unsigned restoring divider, one quotient bit per cycle
module tee_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tee_pkg::DataW-1:0] dividend_i,
  input  logic [tee_pkg::DataW-1:0] divisor_i,
  output logic                      done_o,
  output logic [tee_pkg::DataW-1:0] quot_o,
  output logic [tee_pkg::DataW-1:0] rem_o
);
  import tee_pkg::*;

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [DataW-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DataW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[DataW-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DataW]) begin
        rem_d  = {rem_q[DataW-2:0], quot_q[DataW-1]};
        quot_d = {quot_q[DataW-2:0], 1'b0};
      end else begin
        rem_d  = trial[DataW-1:0];
        quot_d = {quot_q[DataW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

// ----- hw/rtl/tee_datapath.sv -----
// evaluator datapath: accumulator, operator, phase, group stack and alu
module tee_datapath #(
  parameter int unsigned MAX_NEST = tee_pkg::MaxNest
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tee_pkg::cmd_t             cmd_i,
  output tee_pkg::sts_t             sts_o,
  input  logic [1:0]                req_type_i,
  input  logic [tee_pkg::DataW-1:0] tok_value_i,
  input  logic [2:0]                op_code_i,
  input  logic                      last_token_i,
  output logic [tee_pkg::DataW-1:0] value_o,
  output logic                      div_by_zero_o,
  output logic                      nesting_overflow_o
);
  import tee_pkg::*;

  localparam int unsigned LvlW = $clog2(MAX_NEST + 1);
  localparam int unsigned IdxW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  // registered token
  logic [1:0]       kind_q;
  logic [DataW-1:0] val_q;
  logic [2:0]       code_q;
  logic             last_q;

  logic [DataW-1:0] acc_q, acc_d;
  logic [2:0]       pop_q, pop_d;
  logic [1:0]       ph_q, ph_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic             dz_q, dz_d, ov_q, ov_d;

  logic [DataW-1:0] stk_acc [MAX_NEST];
  logic [2:0]       stk_op  [MAX_NEST];
  logic             push;
  logic [DataW-1:0] push_acc;
  logic [2:0]       push_op;
  logic [IdxW-1:0]  top_idx;

  // alu operands latched at start
  logic [DataW-1:0] a_q, b_q;
  logic [2:0]       f_q;
  logic             alu_busy_q;
  logic [DataW-1:0] div_q_w, div_r_w;
  logic             div_done;
  logic             div_start;
  logic [DataW-1:0] alu_res;
  logic             alu_res_ok;
  logic [DataW-1:0] mul_q;
  logic             mul_pend_q;

  assign top_idx = IdxW'(lvl_q - 1'b1);

  // operand selection for a combine
  logic [DataW-1:0] opa, opb;
  logic [2:0]       opf;
  always_comb begin
    if (cmd_i.alu_pop) begin
      opa = stk_acc[top_idx];
      opf = stk_op[top_idx];
      opb = acc_q;
    end else begin
      opa = acc_q;
      opf = pop_q;
      opb = val_q;
    end
  end

  assign div_start = cmd_i.start_alu && (opf == OP_DIV || opf == OP_MOD) && (opb != '0);

  tee_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (opa),
    .divisor_i  (opb),
    .done_o     (div_done),
    .quot_o     (div_q_w),
    .rem_o      (div_r_w)
  );

  logic alu_isdiv_q, alu_zero_q;

  always_comb begin
    alu_res_ok = 1'b0;
    alu_res    = a_q;
    if (alu_busy_q) begin
      if (alu_isdiv_q && !alu_zero_q) begin
        alu_res_ok = div_done;
        alu_res    = (f_q == OP_DIV) ? div_q_w : div_r_w;
      end else if (f_q == OP_MUL) begin
        alu_res_ok = mul_pend_q;
        alu_res    = mul_q;
      end else begin
        alu_res_ok = 1'b1;
        case (f_q)
          OP_ADD:  alu_res = a_q + b_q;
          OP_SUB:  alu_res = a_q - b_q;
          OP_DIV:  alu_res = '1;
          OP_MOD:  alu_res = a_q;
          OP_AND:  alu_res = a_q & b_q;
          OP_OR:   alu_res = a_q | b_q;
          default: alu_res = a_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alu_busy_q <= 1'b0;
      mul_pend_q <= 1'b0;
    end else begin
      mul_pend_q <= alu_busy_q && (f_q == OP_MUL) && !mul_pend_q;
      if (cmd_i.start_alu)  alu_busy_q <= 1'b1;
      else if (alu_res_ok)  alu_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_alu) begin
      a_q         <= opa;
      b_q         <= opb;
      f_q         <= opf;
      alu_isdiv_q <= (opf == OP_DIV || opf == OP_MOD);
      alu_zero_q  <= (opb == '0);
    end
    mul_q <= DataW'(a_q * b_q);
  end

  always_comb begin
    sts_o            = '0;
    sts_o.alu_done   = alu_res_ok;
    sts_o.nest_empty = (lvl_q == '0);
    sts_o.is_last    = last_q;
    if (kind_q == TOK_NUM && ph_q == PH_NEXT) sts_o.needs_alu = 1'b1;
    if (kind_q == TOK_CLOSE && lvl_q != '0) begin
      sts_o.needs_alu = 1'b1;
      sts_o.needs_pop = 1'b1;
    end
  end

  // state update
  always_comb begin
    acc_d    = acc_q;
    pop_d    = pop_q;
    ph_d     = ph_q;
    lvl_d    = lvl_q;
    dz_d     = dz_q;
    ov_d     = ov_q;
    push     = 1'b0;
    push_acc = acc_q;
    push_op  = pop_q;
    if (cmd_i.exec_tok) begin
      case (kind_q)
        TOK_NUM: begin
          if (ph_q == PH_FIRST) begin
            acc_d = val_q;
            ph_d  = PH_OPER;
          end else begin
            pop_d = OP_UNK;
            ph_d  = PH_NEXT;
          end
        end
        TOK_OP: begin
          if (ph_q == PH_OPER) begin
            pop_d = code_q;
            ph_d  = PH_NEXT;
          end
        end
        TOK_OPEN: begin
          if (ph_q == PH_OPER) begin
            pop_d = OP_UNK;
            ph_d  = PH_NEXT;
          end else if (lvl_q >= LvlW'(MAX_NEST)) begin
            ov_d = 1'b1;
          end else begin
            push = 1'b1;
            if (ph_q == PH_FIRST) begin
              push_acc = '0;
              push_op  = OP_ADD;
            end
            lvl_d = lvl_q + 1'b1;
            acc_d = '0;
            ph_d  = PH_FIRST;
          end
        end
        default: begin
          if (ph_q == PH_OPER) begin
            pop_d = OP_UNK;
            ph_d  = PH_NEXT;
          end
        end
      endcase
    end
    if (alu_res_ok) begin
      acc_d = alu_res;
      ph_d  = PH_OPER;
      if (alu_isdiv_q && alu_zero_q) dz_d = 1'b1;
    end
    if (cmd_i.start_alu && cmd_i.alu_pop) lvl_d = lvl_q - 1'b1;
    if (cmd_i.finish) begin
      acc_d = '0;
      pop_d = OP_UNK;
      ph_d  = PH_FIRST;
      lvl_d = '0;
      dz_d  = 1'b0;
      ov_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pop_q <= OP_UNK;
      ph_q  <= PH_FIRST;
      lvl_q <= '0;
      dz_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      pop_q <= pop_d;
      ph_q  <= ph_d;
      lvl_q <= lvl_d;
      dz_q  <= dz_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      kind_q <= req_type_i;
      val_q  <= tok_value_i;
      code_q <= op_code_i;
      last_q <= last_token_i;
    end
    if (push) begin
      stk_acc[IdxW'(lvl_q)] <= push_acc;
      stk_op[IdxW'(lvl_q)]  <= push_op;
    end
    if (cmd_i.finish) begin
      value_o            <= acc_q;
      div_by_zero_o      <= dz_q;
      nesting_overflow_o <= ov_q;
    end
  end
endmodule

// ----- hw/rtl/tee_ctrl.sv -----
// evaluator controller: token sequencing, group folding and output handshake
module tee_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  tee_pkg::sts_t sts_i,
  output tee_pkg::cmd_t cmd_o
);
  import tee_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_WAIT, S_CHECK, S_FOLD, S_FWAIT, S_DONE
  } state_e;

  state_e st_q;
  logic   ovld_q;

  // a new word enters while the output still holds if in idle
  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    cmd_o = '0;
    case (st_q)
      S_IDLE:   cmd_o.load_tok = in_valid_i;
      S_DECODE: begin
        if (sts_i.needs_alu) begin
          cmd_o.start_alu = 1'b1;
          // a close paren combines with the stack top, a number with the accumulator
          cmd_o.alu_pop   = sts_i.needs_pop;
        end else begin
          cmd_o.exec_tok = 1'b1;
        end
      end
      S_FOLD: begin
        cmd_o.start_alu = 1'b1;
        cmd_o.alu_pop   = 1'b1;
      end
      S_DONE:   cmd_o.finish = !ovld_q || !out_stall_i;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ovld_q <= 1'b0;
    end else begin
      if (cmd_o.finish)               ovld_q <= 1'b1;
      else if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
      case (st_q)
        S_IDLE:   if (in_valid_i) st_q <= S_DECODE;
        S_DECODE: st_q <= sts_i.needs_alu ? S_WAIT : S_CHECK;
        S_WAIT:   if (sts_i.alu_done) st_q <= S_CHECK;
        S_CHECK: begin
          if (!sts_i.is_last)        st_q <= S_IDLE;
          else if (sts_i.nest_empty) st_q <= S_DONE;
          else                       st_q <= S_FOLD;
        end
        S_FOLD:   st_q <= S_FWAIT;
        S_FWAIT:  if (sts_i.alu_done) st_q <= S_CHECK;
        S_DONE:   if (cmd_o.finish) st_q <= S_IDLE;
        default:  st_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/token_expression_evaluator_unit.sv -----
// top level of the token expression evaluator
//
// input channel: one token word per handshake (req_type, tok_value, op_code,
// last_token), accepted when in_valid_i is high and in_stall_o is low
// output channel: one result word (value, div_by_zero, nesting_overflow)
// after each token marked last_token, taken when out_valid_o is high and
// out_stall_i is low
// tokens are handled one at a time: each is loaded, decoded and checked,
// and a number that completes a pair or a close paren inside a group first
// waits for its combine; mul uses a registered product, and div or mod by a
// nonzero divisor the bit-serial divider; on the last token each unclosed
// group is folded with a combine of its own, and the result is then presented
// the result sits in an output register; the next token is accepted while
// it waits, but a second result waits until the first is taken
// reset clears accumulator, phase, nesting level and flags; the group
// stack holds no reset and is only read after a push
module token_expression_evaluator_unit #(
  parameter int unsigned MAX_NEST = tee_pkg::MaxNest
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [tee_pkg::DataW-1:0] tok_value_i,
  input  logic [2:0]                op_code_i,
  input  logic                      last_token_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tee_pkg::DataW-1:0] value_o,
  output logic                      div_by_zero_o,
  output logic                      nesting_overflow_o
);
  import tee_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tee_datapath #(.MAX_NEST(MAX_NEST)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_type_i         (req_type_i),
    .tok_value_i        (tok_value_i),
    .op_code_i          (op_code_i),
    .last_token_i       (last_token_i),
    .value_o            (value_o),
    .div_by_zero_o      (div_by_zero_o),
    .nesting_overflow_o (nesting_overflow_o)
  );
endmodule

// ----- hw/rtl/tee_checker.sv -----
// port-level checks of the evaluator, bound to the top level
module tee_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_token_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_o
);
  // a taken word is followed by a busy cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("no busy after take");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_o)))
    else $error("result changed under stall");

  // a result never appears right after a non-final token is taken
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !last_token_i && !out_valid_o) |=> !out_valid_o)
    else $error("spurious result");
endmodule

bind token_expression_evaluator_unit tee_checker u_tee_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_token_i (last_token_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .value_o      (value_o)
);
